### rtl/tspm_pkg.sv
package tspm_pkg;

  localparam int unsigned MAX_CITIES_DEF = 12;

  localparam int unsigned CITY_W     = 4;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned COST_W     = 20;
  localparam int unsigned ACC_W      = COST_W + 1;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CITY_W-1:0] NUM_CITIES_RST = 4'd12;
  localparam logic [CITY_W-1:0] HOME_CITY_RST  = 4'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CITIES = 1'b0,
    CFG_HOME_CITY  = 1'b1
  } cfg_idx_e;

  // control of one read step, aligned with the registered memory data
  typedef struct packed {
    logic act;
    logic take;
    logic first;
    logic last;
    logic single;
    logic wr;
  } step_ctrl_t;

endpackage

### rtl/tsp_min_tour_cost.sv
// minimum closed tour cost over a directed weight matrix (subset dynamic program)
// input stream: one weight entry per transaction; tlast marks the final entry
//   and starts the calculation
// output stream: one transaction with the tour cost per final entry
// configuration: cfg_we_i writes num_cities (index 0) or the start city (index 1);
//   user writes only while no calculation is under way; the block does not enforce it
// the calculation reads the cost table and the weight memory once per cycle
// one calculation at a time; input stays stalled until the result has been
//   moved into the output register
// the output register holds the result while the receiver stalls, and new
//   entries are taken meanwhile
// reset clears the control and the configuration (12 cities, start city 0);
//   weight memory and cost table contents stay undefined until written
module tsp_min_tour_cost #(
  parameter int unsigned MAX_CITIES = tspm_pkg::MAX_CITIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // from_city [3:0], to_city [7:4], weight [23:8]
  input  logic [tspm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tour_cost [19:0], zero fill [23:20]
  output logic [tspm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [tspm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tspm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  import tspm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CITIES);
  localparam int unsigned MW = MAX_CITIES - 1;
  localparam int unsigned TW = MW + CW;

  logic [CITY_W-1:0]   num_cities_q, home_city_q;
  logic [CITY_W-1:0]   from_city, to_city;
  logic [WEIGHT_W-1:0] weight;
  logic                in_acc, wt_we;
  logic [2*CW-1:0]     wt_raddr;
  logic [WEIGHT_W-1:0] wt_rdata;
  logic [TW-1:0]       tbl_raddr, tbl_waddr_seq, tbl_waddr;
  logic [COST_W-1:0]   tbl_rdata, tbl_wdata, best;
  logic                tbl_we;
  step_ctrl_t          ctrl;
  logic                out_free, load;
  logic                out_valid_q, out_valid_d;
  logic [COST_W-1:0]   out_data_q;

  assign from_city = s_axis_tdata[3:0];
  assign to_city   = s_axis_tdata[7:4];
  assign weight    = s_axis_tdata[23:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cities_q <= NUM_CITIES_RST;
      home_city_q  <= HOME_CITY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NUM_CITIES: num_cities_q <= cfg_wdata_i;
        CFG_HOME_CITY:  home_city_q  <= cfg_wdata_i;
      endcase
    end
  end

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign wt_we  = in_acc
               && ({1'b0, from_city} < (CITY_W + 1)'(MAX_CITIES))
               && ({1'b0, to_city} < (CITY_W + 1)'(MAX_CITIES));

  tspm_ram #(
    .AW (2 * CW),
    .DW (WEIGHT_W)
  ) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i ({from_city[CW-1:0], to_city[CW-1:0]}),
    .wdata_i (weight),
    .raddr_i (wt_raddr),
    .rdata_o (wt_rdata)
  );

  tspm_ram #(
    .AW (TW),
    .DW (COST_W)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  tspm_seq #(
    .MAX_CITIES (MAX_CITIES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .num_cities_i (num_cities_q),
    .home_city_i  (home_city_q),
    .in_valid_i   (s_axis_tvalid),
    .in_last_i    (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .out_free_i   (out_free),
    .load_o       (load),
    .wt_raddr_o   (wt_raddr),
    .tbl_raddr_o  (tbl_raddr),
    .tbl_waddr_o  (tbl_waddr_seq),
    .ctrl_o       (ctrl)
  );

  tspm_acc #(
    .TW (TW)
  ) u_acc (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .waddr_i     (tbl_waddr_seq),
    .tbl_rdata_i (tbl_rdata),
    .wt_rdata_i  (wt_rdata),
    .tbl_we_o    (tbl_we),
    .tbl_waddr_o (tbl_waddr),
    .tbl_wdata_o (tbl_wdata),
    .best_o      (best)
  );

  // output register
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= best;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - COST_W){1'b0}}, out_data_q};

endmodule

### rtl/tspm_ram.sv
module tspm_ram #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // write-through when the same entry is read and written in one cycle
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tspm_seq.sv
module tspm_seq #(
  parameter int unsigned MAX_CITIES = tspm_pkg::MAX_CITIES_DEF,
  parameter int unsigned CW         = $clog2(MAX_CITIES),
  parameter int unsigned MW         = MAX_CITIES - 1,
  parameter int unsigned TW         = MW + CW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tspm_pkg::CITY_W-1:0] num_cities_i,
  input  logic [tspm_pkg::CITY_W-1:0] home_city_i,
  input  logic                        in_valid_i,
  input  logic                        in_last_i,
  output logic                        in_ready_o,
  input  logic                        out_free_i,
  output logic                        load_o,
  output logic [2*CW-1:0]             wt_raddr_o,
  output logic [TW-1:0]               tbl_raddr_o,
  output logic [TW-1:0]               tbl_waddr_o,
  output tspm_pkg::step_ctrl_t        ctrl_o
);

  import tspm_pkg::*;

  localparam int unsigned NW = CITY_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_FIN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_WAIT  = 5'b10000
  } state_e;

  state_e     state_q, state_d;
  logic [CW-1:0] s_q, s_d;
  logic [CW-1:0] kl_q, kl_d;
  logic          mzero_q, mzero_d;
  logic [MW-1:0] full_q, full_d;
  logic [MW-1:0] mask_q, mask_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] j_q, j_d;
  step_ctrl_t    ctrl_q, ctrl_d;
  logic [TW-1:0] waddr_q, waddr_d;

  logic [NW-1:0] n_raw, n_eff, nm1, s_raw, s_sat;
  logic [MW-1:0] kbit, rest;
  logic          kin, jin, single;
  logic [CW-1:0] ok, oj;

  function automatic logic [CW-1:0] other_city(input logic [CW-1:0] x,
                                               input logic [CW-1:0] s);
    return (x < s) ? x : x + CW'(1);
  endfunction

  // clamp the configured problem
  always_comb begin
    n_raw = NW'(num_cities_i);
    s_raw = NW'(home_city_i);
    if (n_raw == '0) begin
      n_eff = NW'(1);
    end else if (n_raw > NW'(MAX_CITIES)) begin
      n_eff = NW'(MAX_CITIES);
    end else begin
      n_eff = n_raw;
    end
    nm1   = n_eff - NW'(1);
    s_sat = (s_raw >= n_eff) ? nm1 : s_raw;
  end

  assign kbit   = MW'(1) << k_q;
  assign kin    = |(mask_q & kbit);
  assign rest   = mask_q & ~kbit;
  assign single = (rest == '0);
  assign jin    = |(rest & (MW'(1) << j_q));
  assign ok     = other_city(k_q, s_q);
  assign oj     = other_city(j_q, s_q);

  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    kl_d        = kl_q;
    mzero_d     = mzero_q;
    full_d      = full_q;
    mask_d      = mask_q;
    k_d         = k_q;
    j_d         = j_q;
    ctrl_d      = '0;
    waddr_d     = waddr_q;
    in_ready_o  = 1'b0;
    load_o      = 1'b0;
    wt_raddr_o  = {oj, ok};
    tbl_raddr_o = {rest, j_q};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_last_i) begin
          s_d     = s_sat[CW-1:0];
          mzero_d = (nm1 == '0);
          kl_d    = (nm1 == '0) ? '0 : CW'(nm1 - NW'(1));
          full_d  = ~({MW{1'b1}} << nm1[CW-1:0]);
          mask_d  = MW'(1);
          k_d     = '0;
          j_d     = '0;
          state_d = (nm1 == '0) ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        ctrl_d.act    = 1'b1;
        ctrl_d.take   = kin && (single ? (j_q == '0) : jin);
        ctrl_d.first  = (j_q == '0);
        ctrl_d.last   = (j_q == kl_q);
        ctrl_d.single = single;
        ctrl_d.wr     = kin;
        waddr_d       = {mask_q, k_q};
        wt_raddr_o    = {(single ? s_q : oj), ok};
        tbl_raddr_o   = {rest, j_q};
        if (j_q == kl_q) begin
          j_d = '0;
          if (k_q == kl_q) begin
            k_d = '0;
            if (mask_q == full_q) begin
              state_d = ST_FIN;
            end else begin
              mask_d = mask_q + MW'(1);
            end
          end else begin
            k_d = k_q + CW'(1);
          end
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      ST_FIN: begin
        ctrl_d.act    = 1'b1;
        ctrl_d.take   = 1'b1;
        ctrl_d.first  = (k_q == '0);
        ctrl_d.last   = (k_q == kl_q);
        ctrl_d.single = mzero_q;
        ctrl_d.wr     = 1'b0;
        tbl_raddr_o   = {full_q, k_q};
        wt_raddr_o    = mzero_q ? {s_q, s_q} : {ok, s_q};
        if (k_q == kl_q) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + CW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free_i) begin
          load_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      s_q     <= '0;
      kl_q    <= '0;
      mzero_q <= 1'b0;
      full_q  <= '0;
      mask_q  <= '0;
      k_q     <= '0;
      j_q     <= '0;
      ctrl_q  <= '0;
      waddr_q <= '0;
    end else begin
      state_q <= state_d;
      s_q     <= s_d;
      kl_q    <= kl_d;
      mzero_q <= mzero_d;
      full_q  <= full_d;
      mask_q  <= mask_d;
      k_q     <= k_d;
      j_q     <= j_d;
      ctrl_q  <= ctrl_d;
      waddr_q <= waddr_d;
    end
  end

  assign ctrl_o      = ctrl_q;
  assign tbl_waddr_o = waddr_q;

endmodule

### rtl/tspm_acc.sv
module tspm_acc #(
  parameter int unsigned TW = 15
) (
  input  logic                          clk_i,
  input  tspm_pkg::step_ctrl_t          ctrl_i,
  input  logic [TW-1:0]                 waddr_i,
  input  logic [tspm_pkg::COST_W-1:0]   tbl_rdata_i,
  input  logic [tspm_pkg::WEIGHT_W-1:0] wt_rdata_i,
  output logic                          tbl_we_o,
  output logic [TW-1:0]                 tbl_waddr_o,
  output logic [tspm_pkg::COST_W-1:0]   tbl_wdata_o,
  output logic [tspm_pkg::COST_W-1:0]   best_o
);

  import tspm_pkg::*;

  logic [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0] cand, base;

  always_comb begin
    if (ctrl_i.single) begin
      cand = ACC_W'(wt_rdata_i);
    end else begin
      cand = ACC_W'(tbl_rdata_i) + ACC_W'(wt_rdata_i);
    end
    base  = ctrl_i.first ? {ACC_W{1'b1}} : acc_q;
    acc_d = (ctrl_i.take && (cand < base)) ? cand : base;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.act) begin
      acc_q <= acc_d;
    end
  end

  assign tbl_we_o    = ctrl_i.act && ctrl_i.last && ctrl_i.wr;
  assign tbl_waddr_o = waddr_i;
  assign tbl_wdata_o = acc_d[COST_W-1:0];
  assign best_o      = acc_q[COST_W-1:0];

endmodule

### rtl/tspm_checker.sv
module tspm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tspm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // the final entry closes the input until the calculation is over
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input open right after final entry");

  // a plain entry never produces a result
  a_no_result_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("result without final entry");

  // a new result only comes out of a calculation
  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while input was open");

endmodule

bind tsp_min_tour_cost tspm_checker u_tspm_checker (.*);

### dv/tsp_min_tour_cost_tb.sv
module tsp_min_tour_cost_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tspm_pkg::*;

  localparam int unsigned MAXC          = tspm_pkg::MAX_CITIES_DEF;
  localparam int unsigned CLK_PERIOD    = 4;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned RANDOM_ITEMS  = 110;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned TAIL_OPS      = 40;
  localparam int unsigned STALL_LIMIT   = 1000000;

  typedef enum logic [1:0] {
    OP_ENTRY,
    OP_CFG,
    OP_HOLD
  } matrix_op_kind_e;

  typedef struct {
    matrix_op_kind_e         kind;
    logic [CITY_W-1:0]       from_city;
    logic [CITY_W-1:0]       to_city;
    logic [WEIGHT_W-1:0]     weight;
    logic                    last_entry;
    cfg_idx_e                cfg_idx;
    logic [CFG_DATA_W-1:0]   cfg_val;
  } matrix_op_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // from_city [3:0], to_city [7:4], weight [23:8]
  logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
  logic                    s_axis_tlast = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // tour_cost [19:0], zero fill [23:20]
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = CFG_NUM_CITIES;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i = '0;

  matrix_op_t              matrix_ops[$];
  logic [COST_W-1:0]       owed_tour_costs[$];
  logic [WEIGHT_W-1:0]     weights [MAXC][MAXC];
  int unsigned             path_cost [1 << (MAXC - 1)][MAXC];
  logic [CITY_W-1:0]       cities_cfg = NUM_CITIES_RST;
  logic [CITY_W-1:0]       start_cfg = HOME_CITY_RST;

  int unsigned             owed_count = 0;
  int unsigned             quiet_cycles = 0;
  int unsigned             idle_cycles = 0;
  int unsigned             hold_requests = 0;
  logic                    tail_mode = 1'b0;
  logic                    ops_done = 1'b0;
  int unsigned             fail_count = 0;
  int unsigned             entries_taken = 0;
  int unsigned             costs_checked = 0;
  int unsigned             cfg_writes = 0;

  tsp_min_tour_cost uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [COST_W-1:0] got,
                                 input logic [COST_W-1:0] want);
    fail_count++;
    $display("%0t mismatch: %s, got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic push_entry(input int unsigned fc, input int unsigned tc,
                            input logic [WEIGHT_W-1:0] w, input logic fin);
    matrix_op_t op;
    op = '{kind: OP_ENTRY, from_city: CITY_W'(fc), to_city: CITY_W'(tc), weight: w,
           last_entry: fin, cfg_idx: CFG_NUM_CITIES, cfg_val: '0};
    matrix_ops.insert(matrix_ops.size(), op);
  endtask

  task automatic push_cfg(input cfg_idx_e idx, input int unsigned val);
    matrix_op_t op;
    op = '{kind: OP_CFG, from_city: '0, to_city: '0, weight: '0, last_entry: 1'b0,
           cfg_idx: idx, cfg_val: CFG_DATA_W'(val)};
    matrix_ops.insert(matrix_ops.size(), op);
  endtask

  task automatic push_hold();
    matrix_op_t op;
    op = '{kind: OP_HOLD, from_city: '0, to_city: '0, weight: '0, last_entry: 1'b0,
           cfg_idx: CFG_NUM_CITIES, cfg_val: '0};
    matrix_ops.insert(matrix_ops.size(), op);
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // cheapest closed tour from the start city, subset by subset
  function automatic logic [COST_W-1:0] held_karp_cost();
    int unsigned n;
    int unsigned s;
    int unsigned m;
    int unsigned full;
    int unsigned best;
    int unsigned v;
    int unsigned rest;
    int unsigned others [MAXC];
    n = cities_cfg;
    if (n == 0) n = 1;
    if (n > MAXC) n = MAXC;
    s = start_cfg;
    if (s >= n) s = n - 1;
    if (n == 1) return COST_W'(weights[s][s]);
    m = 0;
    for (int unsigned c = 0; c < n; c++) begin
      if (c != s) begin
        others[m] = c;
        m++;
      end
    end
    full = (1 << m) - 1;
    for (int unsigned mask = 1; mask <= full; mask++) begin
      for (int unsigned k = 0; k < m; k++) begin
        if (((mask >> k) & 1) == 0) continue;
        rest = mask ^ (1 << k);
        if (rest == 0) begin
          best = weights[s][others[k]];
        end else begin
          best = '1;
          for (int unsigned j = 0; j < m; j++) begin
            if (((rest >> j) & 1) == 0) continue;
            v = path_cost[rest][j] + weights[others[j]][others[k]];
            if (v < best) best = v;
          end
        end
        path_cost[mask][k] = best;
      end
    end
    best = '1;
    for (int unsigned k = 0; k < m; k++) begin
      v = path_cost[full][k] + weights[others[k]][s];
      if (v < best) best = v;
    end
    return COST_W'(best);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : matrix_driver
    matrix_op_t  op;
    logic        load;
    logic        cfg_go;
    int unsigned gap_left;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      cfg_we_i      <= 1'b0;
      cfg_idx_i     <= CFG_NUM_CITIES;
      cfg_wdata_i   <= '0;
      gap_left = 0;
    end else begin
      load = 1'b0;
      cfg_go = 1'b0;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_axis_tvalid && !tail_mode && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(1, 13);
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (matrix_ops.size() > 0 && !cfg_we_i) begin
          case (matrix_ops[0].kind)
            OP_ENTRY: begin
              op = matrix_ops.pop_front();
              load = 1'b1;
            end
            OP_HOLD: begin
              void'(matrix_ops.pop_front());
              hold_requests <= hold_requests + 1;
            end
            default: begin
              // block must be idle before a register write
              if (!s_axis_tvalid && owed_count == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                op = matrix_ops.pop_front();
                cfg_go = 1'b1;
              end
            end
          endcase
        end
        s_axis_tvalid <= load;
        if (load) begin
          s_axis_tdata <= {op.weight, op.to_city, op.from_city};
          s_axis_tlast <= op.last_entry;
        end
        tail_mode <= matrix_ops.size() <= TAIL_OPS;
        ops_done  <= matrix_ops.size() == 0 && !load && !cfg_go;
      end
      cfg_we_i <= cfg_go;
      if (cfg_go) begin
        cfg_idx_i   <= op.cfg_idx;
        cfg_wdata_i <= op.cfg_val;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : cost_receiver
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned holds_served;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      calm_left = 0;
      holds_served = 0;
    end else begin
      if (holds_served != hold_requests) begin
        holds_served++;
        stall_left = HOLD_CYCLES;
        calm_left = 0;
      end else if (stall_left == 0 && calm_left == 0 && !tail_mode) begin
        case ($urandom_range(0, 3))
          0: stall_left = $urandom_range(1, 13);
          1: calm_left = $urandom_range(20, 150);
          default: calm_left = $urandom_range(1, 6);
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (calm_left > 0) calm_left--;
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : tour_monitor
    logic              in_acc;
    logic              out_acc;
    logic [COST_W-1:0] want;
    if (!rst_ni) begin
      cities_cfg = NUM_CITIES_RST;
      start_cfg = HOME_CITY_RST;
      owed_count   <= 0;
      quiet_cycles <= 0;
      idle_cycles  <= 0;
    end else begin
      in_acc = s_axis_tvalid && s_axis_tready;
      out_acc = m_axis_tvalid && m_axis_tready;
      if (cfg_we_i) begin
        cfg_writes++;
        if (cfg_idx_i == CFG_NUM_CITIES) cities_cfg = cfg_wdata_i;
        else start_cfg = cfg_wdata_i;
      end
      if (in_acc) begin
        entries_taken++;
        if (s_axis_tdata[3:0] < MAXC && s_axis_tdata[7:4] < MAXC) begin
          weights[s_axis_tdata[3:0]][s_axis_tdata[7:4]] = s_axis_tdata[23:8];
        end
        if (s_axis_tlast) begin
          owed_tour_costs.insert(owed_tour_costs.size(), held_karp_cost());
        end
      end
      if (out_acc) begin
        if (owed_tour_costs.size() == 0) begin
          report_mismatch("tour cost with no final entry pending", m_axis_tdata[COST_W-1:0], '0);
        end else begin
          want = owed_tour_costs.pop_front();
          costs_checked++;
          if (m_axis_tdata[COST_W-1:0] !== want) begin
            report_mismatch("tour_cost", m_axis_tdata[COST_W-1:0], want);
          end
        end
      end
      owed_count   <= owed_tour_costs.size();
      quiet_cycles <= (in_acc || out_acc) ? 0 : quiet_cycles + 1;
      idle_cycles  <= (in_acc || out_acc) ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("tsp_min_tour_cost regression: fail");
    $finish;
  end

  initial begin : regression
    int unsigned random_items;
    int unsigned n_cfg;
    int unsigned n_eff;
    int unsigned span;
    int unsigned fc;
    int unsigned tc;
    int unsigned st;
    logic        fin;

    // full matrix at maximum weight, reset configuration: largest possible cost
    for (int unsigned r = 0; r < MAXC; r++) begin
      for (int unsigned c = 0; c < MAXC; c++) begin
        push_entry(r, c, '1, r == MAXC - 1 && c == MAXC - 1);
      end
    end
    // oversized city count and start city saturate; out-of-range entries dropped
    push_cfg(CFG_NUM_CITIES, 15);
    push_cfg(CFG_HOME_CITY, 15);
    for (int i = 0; i < 4; i++) begin
      push_entry($urandom_range(0, MAXC - 1), $urandom_range(0, MAXC - 1), pick_weight(), 1'b0);
    end
    push_entry(3, 14, 16'h1234, 1'b0);
    push_entry(15, 15, '0, 1'b1);
    // city count zero, single city with zero weight
    push_cfg(CFG_NUM_CITIES, 0);
    push_cfg(CFG_HOME_CITY, 0);
    push_entry(0, 0, '0, 1'b1);
    // single city, start beyond the count
    push_cfg(CFG_NUM_CITIES, 1);
    push_cfg(CFG_HOME_CITY, 9);
    push_entry(0, 0, 16'hA5A5, 1'b1);
    push_cfg(CFG_NUM_CITIES, 2);
    push_cfg(CFG_HOME_CITY, 1);
    push_entry(0, 1, pick_weight(), 1'b0);
    push_entry(1, 0, pick_weight(), 1'b1);
    push_cfg(CFG_NUM_CITIES, 3);
    push_cfg(CFG_HOME_CITY, 2);
    push_entry(2, 0, '0, 1'b0);
    push_entry(0, 1, '1, 1'b0);
    push_entry(1, 2, pick_weight(), 1'b1);

    // long output hold while entries keep coming
    push_cfg(CFG_NUM_CITIES, 3);
    push_cfg(CFG_HOME_CITY, 0);
    push_hold();
    for (int i = 0; i < 12; i++) begin
      push_entry($urandom_range(0, 2), $urandom_range(0, 2), pick_weight(), i % 3 == 2);
    end

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      n_cfg = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 8) : $urandom_range(0, 6);
      n_eff = (n_cfg == 0) ? 1 : n_cfg;
      st = $urandom_range(0, 15);
      if ($urandom_range(0, 1) == 0) begin
        push_cfg(CFG_NUM_CITIES, n_cfg);
        push_cfg(CFG_HOME_CITY, st);
      end else begin
        push_cfg(CFG_HOME_CITY, st);
        push_cfg(CFG_NUM_CITIES, n_cfg);
      end
      span = $urandom_range(2, 12);
      for (int unsigned i = 0; i < span; i++) begin
        if ($urandom_range(0, 4) != 0) begin
          fc = $urandom_range(0, n_eff - 1);
          tc = $urandom_range(0, n_eff - 1);
        end else begin
          fc = $urandom_range(0, 15);
          tc = $urandom_range(0, 15);
        end
        fin = (i == span - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 5) == 0);
        push_entry(fc, tc, pick_weight(), fin);
        if (fin || (fc < MAXC && tc < MAXC)) random_items++;
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (!ops_done || owed_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (owed_tour_costs.size() != 0) begin
      report_mismatch("tour cost never delivered", '0, owed_tour_costs[0]);
    end
    $display("run covered %0d matrix entries and %0d register writes", entries_taken,
             cfg_writes);
    $display("%0d tour costs checked, up to twelve cities, one long output hold",
             costs_checked);
    if (fail_count == 0) begin
      $display("tsp_min_tour_cost regression: pass");
    end else begin
      $display("tsp_min_tour_cost regression: fail");
    end
    $finish;
  end

endmodule
